@@ hw/rtl/lsqe_pkg.sv @@
// Shared types and constants for the line segment quad expander.
// Holds the microcode word layout, step labels and datapath widths.
// No dependencies; compile first.
`default_nettype none

package lsqe_pkg;

  localparam int COORD_W = 18;
  localparam int HW_W    = 16;
  localparam int VNUM_W  = 32;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int SQ_W    = 2 * DIFF_W;
  localparam int ROOT_W  = DIFF_W;
  localparam int QUO_W   = HW_W + 1;
  localparam int NUM_W   = 36;
  localparam int STEP_W  = 4;
  localparam int CNT_W   = 5;

  localparam logic [HW_W-1:0] HW_RESET = 16'd3;

  localparam logic [CNT_W-1:0] SQRT_ITERS = 5'(ROOT_W - 1);
  localparam logic [CNT_W-1:0] DIV_ITERS  = 5'(QUO_W - 1);

  localparam logic [STEP_W-1:0] STEP_WAIT  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MXX   = 4'd1;
  localparam logic [STEP_W-1:0] STEP_MYY   = 4'd2;
  localparam logic [STEP_W-1:0] STEP_ADD   = 4'd3;
  localparam logic [STEP_W-1:0] STEP_ZCHK  = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SQRT  = 4'd5;
  localparam logic [STEP_W-1:0] STEP_MNX   = 4'd6;
  localparam logic [STEP_W-1:0] STEP_MNY   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_DINIT = 4'd8;
  localparam logic [STEP_W-1:0] STEP_DIV   = 4'd9;
  localparam logic [STEP_W-1:0] STEP_NORM  = 4'd10;
  localparam logic [STEP_W-1:0] STEP_EMIT0 = 4'd11;
  localparam logic [STEP_W-1:0] STEP_EMIT1 = 4'd12;
  localparam logic [STEP_W-1:0] STEP_EMIT2 = 4'd13;
  localparam logic [STEP_W-1:0] STEP_EMIT3 = 4'd14;

  localparam logic [1:0] CORNER_0 = 2'd0;
  localparam logic [1:0] CORNER_1 = 2'd1;
  localparam logic [1:0] CORNER_2 = 2'd2;
  localparam logic [1:0] CORNER_3 = 2'd3;

  localparam logic [2:0] CFG_IDX_HALF_WIDTH = 3'd0;

  typedef enum logic [2:0] {
    MUL_NONE = 3'd0,
    MUL_DXDX = 3'd1,
    MUL_DYDY = 3'd2,
    MUL_DYHW = 3'd3,
    MUL_DXHW = 3'd4
  } lsqe_mul_t;

  typedef enum logic [2:0] {
    COND_NONE   = 3'd0,
    COND_ALWAYS = 3'd1,
    COND_NOACC  = 3'd2,
    COND_ZERO   = 3'd3,
    COND_LOOP   = 3'd4
  } lsqe_cond_t;

  typedef struct packed {
    logic              in_rdy;
    lsqe_mul_t         mul;
    logic              sum_mov;
    logic              sum_add;
    logic              sqrt_init;
    logic              sqrt_step;
    logic              numa_ld;
    logic              div_init;
    logic              div_step;
    logic              norm;
    logic              emit;
    logic [1:0]        corner;
    logic              cnt_ld;
    logic [CNT_W-1:0]  cnt_val;
    lsqe_cond_t        cond;
    logic [STEP_W-1:0] target;
  } lsqe_cw_t;

  typedef struct packed {
    logic accept;
    logic sum_zero;
    logic out_busy;
  } lsqe_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/lsqe_ifs.sv @@
// Channel interfaces: segment words in, vertex words out.
// Depends on lsqe_pkg for field widths.
`default_nettype none

interface lsqe_seg_if import lsqe_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] start_x;
  logic signed [COORD_W-1:0] start_y;
  logic signed [COORD_W-1:0] end_x;
  logic signed [COORD_W-1:0] end_y;
  logic                      frame_start;

  modport source (output valid, start_x, start_y, end_x, end_y, frame_start, input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, frame_start, output ready);
endinterface

interface lsqe_vtx_if import lsqe_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] vertex_x;
  logic signed [COORD_W-1:0] vertex_y;
  logic                      corner_u;
  logic                      corner_v;
  logic [VNUM_W-1:0]         vertex_number;
  logic                      last_corner;

  modport source (output valid, vertex_x, vertex_y, corner_u, corner_v, vertex_number,
                  last_corner, input ready);
  modport sink (input valid, vertex_x, vertex_y, corner_u, corner_v, vertex_number,
                last_corner, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/lsqe_cfg.sv @@
// APB-style register port holding the half width register.
// Depends on lsqe_pkg.
`default_nettype none

module lsqe_cfg import lsqe_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            psel,
  input  wire logic            penable,
  input  wire logic            pwrite,
  input  wire logic [2:0]      paddr,
  input  wire logic [31:0]     pwdata,
  output logic      [31:0]     prdata,
  output logic                 pready,
  output logic      [HW_W-1:0] half_width
);

  logic [HW_W-1:0] hw_r;
  logic [HW_W-1:0] hw_nxt;
  logic            hit;

  assign pready     = 1'b1;
  assign hit        = (paddr == 3'(4 * CFG_IDX_HALF_WIDTH));
  assign half_width = hw_r;

  always_comb begin
    hw_nxt = hw_r;
    if (psel && penable && pwrite && hit) begin
      hw_nxt = pwdata[HW_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (hit) begin
      prdata = {{(32-HW_W){1'b0}}, hw_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hw_r <= HW_RESET;
    end else begin
      hw_r <= hw_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lsqe_urom.sv @@
// Microcode store: one control word per program step.
// Depends on lsqe_pkg for the word layout and step labels.
`default_nettype none

module lsqe_urom import lsqe_pkg::*; (
  input  wire logic [STEP_W-1:0] pc,
  output lsqe_cw_t               cw
);

  always_comb begin
    cw = '0;
    case (pc)
      STEP_WAIT: begin
        cw.in_rdy = 1'b1;
        cw.cond   = COND_NOACC;
        cw.target = STEP_WAIT;
      end
      STEP_MXX: begin
        cw.mul = MUL_DXDX;
      end
      STEP_MYY: begin
        cw.mul     = MUL_DYDY;
        cw.sum_mov = 1'b1;
      end
      STEP_ADD: begin
        cw.sum_add = 1'b1;
      end
      STEP_ZCHK: begin
        cw.sqrt_init = 1'b1;
        cw.cnt_ld    = 1'b1;
        cw.cnt_val   = SQRT_ITERS;
        cw.cond      = COND_ZERO;
        cw.target    = STEP_WAIT;
      end
      STEP_SQRT: begin
        cw.sqrt_step = 1'b1;
        cw.cond      = COND_LOOP;
        cw.target    = STEP_SQRT;
      end
      STEP_MNX: begin
        cw.mul = MUL_DYHW;
      end
      STEP_MNY: begin
        cw.mul     = MUL_DXHW;
        cw.numa_ld = 1'b1;
      end
      STEP_DINIT: begin
        cw.div_init = 1'b1;
        cw.cnt_ld   = 1'b1;
        cw.cnt_val  = DIV_ITERS;
      end
      STEP_DIV: begin
        cw.div_step = 1'b1;
        cw.cond     = COND_LOOP;
        cw.target   = STEP_DIV;
      end
      STEP_NORM: begin
        cw.norm = 1'b1;
      end
      STEP_EMIT0: begin
        cw.emit   = 1'b1;
        cw.corner = CORNER_0;
      end
      STEP_EMIT1: begin
        cw.emit   = 1'b1;
        cw.corner = CORNER_1;
      end
      STEP_EMIT2: begin
        cw.emit   = 1'b1;
        cw.corner = CORNER_2;
      end
      STEP_EMIT3: begin
        cw.emit   = 1'b1;
        cw.corner = CORNER_3;
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_WAIT;
      end
      default: begin
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_WAIT;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/lsqe_seq.sv @@
// Microcode sequencer: step counter, loop counter and conditional jumps.
// Depends on lsqe_pkg; reads control words from lsqe_urom.
`default_nettype none

module lsqe_seq import lsqe_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire lsqe_stat_t st,
  output lsqe_cw_t        cw,
  output logic            go
);

  logic [STEP_W-1:0] pc_r;
  logic [STEP_W-1:0] pc_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [CNT_W-1:0]  cnt_nxt;
  logic              stall;

  lsqe_urom u_urom (
    .pc (pc_r),
    .cw (cw)
  );

  assign stall = cw.emit && st.out_busy;
  assign go    = !stall;

  always_comb begin
    pc_nxt  = pc_r + 4'd1;
    cnt_nxt = cnt_r;
    if (stall) begin
      pc_nxt = pc_r;
    end else begin
      case (cw.cond)
        COND_NONE: begin
          pc_nxt = pc_r + 4'd1;
        end
        COND_ALWAYS: begin
          pc_nxt = cw.target;
        end
        COND_NOACC: begin
          if (!st.accept) begin
            pc_nxt = cw.target;
          end
        end
        COND_ZERO: begin
          if (st.sum_zero) begin
            pc_nxt = cw.target;
          end
        end
        COND_LOOP: begin
          if (cnt_r != '0) begin
            pc_nxt  = cw.target;
            cnt_nxt = cnt_r - 5'd1;
          end
        end
        default: begin
          pc_nxt = STEP_WAIT;
        end
      endcase
      if (cw.cnt_ld) begin
        cnt_nxt = cw.cnt_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= STEP_WAIT;
      cnt_r <= '0;
    end else begin
      pc_r  <= pc_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/lsqe_dp.sv @@
// Datapath: segment registers, shared multiplier, bit-serial square root,
// two-lane restoring divider, corner adders and the output register.
// Depends on lsqe_pkg and the channel interfaces in lsqe_ifs.
`default_nettype none

module lsqe_dp import lsqe_pkg::*; (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire lsqe_cw_t        cw,
  input  wire logic            go,
  input  wire logic [HW_W-1:0] half_width,
  output lsqe_stat_t           st,
  lsqe_seg_if.sink             in_seg,
  lsqe_vtx_if.source           out_vtx
);

  logic signed [COORD_W-1:0] x0_r, y0_r, x1_r, y1_r;
  logic [DIFF_W-1:0]         adx_r, ady_r;
  logic                      sx_r, sy_r;
  logic signed [DIFF_W-1:0]  dx_in, dy_in;
  logic [SQ_W-1:0]           prod_r, sum_r;
  logic [DIFF_W-1:0]         ma, mb;
  logic [SQ_W-1:0]           rad_r;
  logic [20:0]               rem_r;
  logic [ROOT_W-1:0]         root_r;
  logic [22:0]               rem_sh, trial;
  logic                      sq_ge;
  logic [NUM_W-1:0]          numa_r, na, nb;
  logic [ROOT_W:0]           den;
  logic [19:0]               drem_r [2];
  logic [QUO_W-1:0]          dlo_r [2];
  logic [20:0]               dt [2];
  logic                      dge [2];
  logic signed [COORD_W-1:0] nx_r, ny_r;
  logic [VNUM_W-1:0]         vcnt_r, vcnt_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [COORD_W-1:0] vx_r, vy_r;
  logic                      u_r, v_r, last_r;
  logic [VNUM_W-1:0]         vnum_r;
  logic                      accept, fire, minus, at_end;
  logic signed [COORD_W-1:0] bx, by;
  logic signed [COORD_W:0]   sxs, sys;
  logic signed [COORD_W-1:0] vx_sat, vy_sat;

  function automatic logic signed [COORD_W-1:0] sat19(input logic signed [COORD_W:0] s);
    logic signed [COORD_W-1:0] r;
    if (s[COORD_W] != s[COORD_W-1]) begin
      r = s[COORD_W] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
    end else begin
      r = s[COORD_W-1:0];
    end
    return r;
  endfunction

  assign in_seg.ready = cw.in_rdy;
  assign accept       = in_seg.valid && cw.in_rdy;
  assign fire         = cw.emit && go;

  assign st.accept   = accept;
  assign st.sum_zero = (sum_r == '0);
  assign st.out_busy = out_valid_r && !out_vtx.ready;

  assign dx_in = {in_seg.end_x[COORD_W-1], in_seg.end_x}
               - {in_seg.start_x[COORD_W-1], in_seg.start_x};
  assign dy_in = {in_seg.end_y[COORD_W-1], in_seg.end_y}
               - {in_seg.start_y[COORD_W-1], in_seg.start_y};

  always_comb begin
    ma = adx_r;
    mb = adx_r;
    case (cw.mul)
      MUL_DXDX: begin
        ma = adx_r;
        mb = adx_r;
      end
      MUL_DYDY: begin
        ma = ady_r;
        mb = ady_r;
      end
      MUL_DYHW: begin
        ma = ady_r;
        mb = {{(DIFF_W-HW_W){1'b0}}, half_width};
      end
      MUL_DXHW: begin
        ma = adx_r;
        mb = {{(DIFF_W-HW_W){1'b0}}, half_width};
      end
      default: begin
        ma = adx_r;
        mb = adx_r;
      end
    endcase
  end

  assign rem_sh = {rem_r, rad_r[SQ_W-1:SQ_W-2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign sq_ge  = (rem_sh >= trial);

  assign den = {root_r, 1'b0};
  assign na  = numa_r;
  assign nb  = {prod_r[NUM_W-2:0], 1'b0} + {{(NUM_W-ROOT_W){1'b0}}, root_r};

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      dt[i]  = {drem_r[i], dlo_r[i][QUO_W-1]};
      dge[i] = (dt[i] >= {1'b0, den});
    end
  end

  assign at_end = cw.corner[1];
  assign minus  = cw.corner[1] ^ cw.corner[0];
  assign bx     = at_end ? x1_r : x0_r;
  assign by     = at_end ? y1_r : y0_r;
  assign sxs    = minus ? ({bx[COORD_W-1], bx} - {nx_r[COORD_W-1], nx_r})
                        : ({bx[COORD_W-1], bx} + {nx_r[COORD_W-1], nx_r});
  assign sys    = minus ? ({by[COORD_W-1], by} - {ny_r[COORD_W-1], ny_r})
                        : ({by[COORD_W-1], by} + {ny_r[COORD_W-1], ny_r});
  assign vx_sat = sat19(sxs);
  assign vy_sat = sat19(sys);

  always_comb begin
    vcnt_nxt = vcnt_r;
    if (accept && in_seg.frame_start) begin
      vcnt_nxt = '0;
    end else if (fire) begin
      vcnt_nxt = vcnt_r + 32'd1;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_vtx.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcnt_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vcnt_r      <= vcnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      x0_r  <= in_seg.start_x;
      y0_r  <= in_seg.start_y;
      x1_r  <= in_seg.end_x;
      y1_r  <= in_seg.end_y;
      sx_r  <= dx_in[DIFF_W-1];
      sy_r  <= dy_in[DIFF_W-1];
      adx_r <= dx_in[DIFF_W-1] ? DIFF_W'(-dx_in) : DIFF_W'(dx_in);
      ady_r <= dy_in[DIFF_W-1] ? DIFF_W'(-dy_in) : DIFF_W'(dy_in);
    end
    if (cw.mul != MUL_NONE) begin
      prod_r <= ma * mb;
    end
    if (cw.sum_mov) begin
      sum_r <= prod_r;
    end else if (cw.sum_add) begin
      sum_r <= sum_r + prod_r;
    end
    if (cw.sqrt_init) begin
      rad_r  <= sum_r;
      rem_r  <= '0;
      root_r <= '0;
    end else if (cw.sqrt_step) begin
      rad_r  <= {rad_r[SQ_W-3:0], 2'b00};
      rem_r  <= sq_ge ? 21'(rem_sh - trial) : rem_sh[20:0];
      root_r <= {root_r[ROOT_W-2:0], sq_ge};
    end
    if (cw.numa_ld) begin
      numa_r <= nb;
    end
    if (cw.div_init) begin
      drem_r[0] <= {1'b0, na[NUM_W-1:QUO_W]};
      dlo_r[0]  <= na[QUO_W-1:0];
      drem_r[1] <= {1'b0, nb[NUM_W-1:QUO_W]};
      dlo_r[1]  <= nb[QUO_W-1:0];
    end else if (cw.div_step) begin
      for (int i = 0; i < 2; i++) begin
        drem_r[i] <= dge[i] ? 20'(dt[i] - {1'b0, den}) : dt[i][19:0];
        dlo_r[i]  <= {dlo_r[i][QUO_W-2:0], dge[i]};
      end
    end
    if (cw.norm) begin
      nx_r <= sy_r ? {1'b0, dlo_r[0]} : COORD_W'(0) - {1'b0, dlo_r[0]};
      ny_r <= sx_r ? COORD_W'(0) - {1'b0, dlo_r[1]} : {1'b0, dlo_r[1]};
    end
    if (fire) begin
      vx_r   <= vx_sat;
      vy_r   <= vy_sat;
      u_r    <= minus;
      v_r    <= at_end;
      vnum_r <= vcnt_r;
      last_r <= (cw.corner == CORNER_3);
    end
  end

  assign out_vtx.valid         = out_valid_r;
  assign out_vtx.vertex_x      = vx_r;
  assign out_vtx.vertex_y      = vy_r;
  assign out_vtx.corner_u      = u_r;
  assign out_vtx.corner_v      = v_r;
  assign out_vtx.vertex_number = vnum_r;
  assign out_vtx.last_corner   = last_r;

`ifndef SYNTHESIS
  a_quo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cw.norm |-> ({1'b0, dlo_r[0]} <= {2'b00, half_width}
              && {1'b0, dlo_r[1]} <= {2'b00, half_width}))
    else $error("normal component exceeds half width");

  a_sqrt_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.mul == MUL_DYHW) |->
      ((40'(root_r) * 40'(root_r) <= 40'(sum_r))
    && ((40'(root_r) + 40'd1) * (40'(root_r) + 40'd1) > 40'(sum_r))))
    else $error("square root result is not the floor root");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> !(out_valid_r && !out_vtx.ready))
    else $error("vertex word overwritten before it was taken");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !(cw.emit || cw.div_step || cw.sqrt_step))
    else $error("segment accepted while a segment is in flight");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/line_segment_quad_expander.sv @@
// Line segment to quad expander: takes one 2-D segment word, emits four
// corner vertex words offset by the half width along the segment normal.
// Depends on lsqe_pkg, lsqe_ifs, lsqe_cfg, lsqe_seq and lsqe_dp.
//
// A segment is accepted, then the squared length is formed from two products
// and their sum and checked for zero, nineteen square root steps run (one
// result bit per cycle), the divides are set up, seventeen divide steps
// produce both normal components at once, the signs are applied and the
// four corners are emitted, one word per cycle while the output side keeps
// up. A zero-length segment emits nothing and returns to waiting after the
// zero check. The microcode sequencer runs one control word per cycle unless
// a stalled output holds the emit step. The last corner waits in the
// output register while the next segment is accepted. half_width is at byte
// address 0 and must only be written while the block is idle.
`default_nettype none

module line_segment_quad_expander import lsqe_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  lsqe_seg_if.sink         in_seg,
  lsqe_vtx_if.source       out_vtx,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  logic [HW_W-1:0] half_width;
  lsqe_cw_t        cw;
  lsqe_stat_t      st;
  logic            go;

  lsqe_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .half_width (half_width)
  );

  lsqe_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .cw    (cw),
    .go    (go)
  );

  lsqe_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cw         (cw),
    .go         (go),
    .half_width (half_width),
    .st         (st),
    .in_seg     (in_seg),
    .out_vtx    (out_vtx)
  );

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
// Testbench for line_segment_quad_expander: drives segment words, predicts the
// four corner vertex words of each quad and checks them in order.
// Depends on lsqe_pkg, lsqe_ifs and the RTL of the block.

module tb;
  import lsqe_pkg::*;

  localparam int            SETTLE_CYCLES = 60;
  localparam int            STALL_CYCLES  = 400;
  localparam int            WATCHDOG_MAX  = 5000;
  localparam int            PRINT_MAX     = 20;
  localparam longint        COORD_HI      = (longint'(1) <<< (COORD_W - 1)) - 1;
  localparam longint        COORD_LO      = -(longint'(1) <<< (COORD_W - 1));
  localparam logic [2:0]    HALF_WIDTH_ADDR = 3'(4 * CFG_IDX_HALF_WIDTH);
  localparam logic [2:0]    SPARE_ADDR      = 3'(4 * (CFG_IDX_HALF_WIDTH + 1));

  typedef struct {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic                      frame_start;
  } segment_t;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      u;
    logic                      v;
    logic [VNUM_W-1:0]         num;
    logic                      last;
  } corner_t;

  logic clk;
  logic rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lsqe_seg_if seg_bus ();
  lsqe_vtx_if vtx_bus ();

  line_segment_quad_expander u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_seg  (seg_bus),
    .out_vtx (vtx_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  segment_t          seg_q[$];
  segment_t          seg_on_bus;
  corner_t           corners_due[$];
  logic [HW_W-1:0]   hw_shadow;
  logic [VNUM_W-1:0] next_vertex;
  int segs_sent;
  int segs_taken;
  int degenerate_segs;
  int corners_checked;
  int n_errors;
  int send_gap_pct;
  int recv_stall_pct;
  int stall_left;
  int idle_cycles;
  bit stall_toggle;
  bit stall_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    n_errors++;
    if (n_errors <= PRINT_MAX) $display("MISMATCH: %s", msg);
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned val);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 20; b >= 0; b--) begin
      trial = root | (longint'(1) << b);
      if (trial * trial <= val) root = trial;
    end
    return root;
  endfunction

  function automatic longint round_scale(input longint num, input longint unsigned hw,
                                         input longint unsigned den);
    longint unsigned mag;
    longint unsigned q;
    mag = longint'(num < 0 ? -num : num) * hw;
    q = (2 * mag + den) / (2 * den);
    return num < 0 ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [COORD_W-1:0] clamp_coord(input longint val);
    if (val > COORD_HI) return COORD_W'(COORD_HI);
    if (val < COORD_LO) return COORD_W'(COORD_LO);
    return COORD_W'(val);
  endfunction

  task automatic predict_quad(input segment_t s);
    longint dx, dy, nx, ny, bx, by;
    longint unsigned sum, len;
    logic [1:0] c;
    corner_t cn;
    if (s.frame_start) next_vertex = '0;
    dx = longint'(s.ex) - longint'(s.sx);
    dy = longint'(s.ey) - longint'(s.sy);
    sum = dx * dx + dy * dy;
    if (sum == 0) begin
      degenerate_segs++;
      return;
    end
    len = int_sqrt(sum);
    nx = round_scale(-dy, hw_shadow, len);
    ny = round_scale(dx, hw_shadow, len);
    for (int k = 0; k < 4; k++) begin
      c = 2'(k);
      cn.u = (c == CORNER_1 || c == CORNER_2);
      cn.v = (c == CORNER_2 || c == CORNER_3);
      bx = cn.v ? longint'(s.ex) : longint'(s.sx);
      by = cn.v ? longint'(s.ey) : longint'(s.sy);
      cn.x = clamp_coord(cn.u ? bx - nx : bx + nx);
      cn.y = clamp_coord(cn.u ? by - ny : by + ny);
      cn.num = next_vertex;
      cn.last = (c == CORNER_3);
      corners_due = {corners_due, cn};
      next_vertex = next_vertex + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seg_bus.valid <= 1'b0;
    end else begin
      if (seg_bus.valid && seg_bus.ready) begin
        predict_quad(seg_on_bus);
        segs_taken++;
      end
      if (!seg_bus.valid || seg_bus.ready) begin
        if (seg_q.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          seg_on_bus = seg_q.pop_front();
          seg_bus.start_x     <= seg_on_bus.sx;
          seg_bus.start_y     <= seg_on_bus.sy;
          seg_bus.end_x       <= seg_on_bus.ex;
          seg_bus.end_y       <= seg_on_bus.ey;
          seg_bus.frame_start <= seg_on_bus.frame_start;
          seg_bus.valid       <= 1'b1;
        end else begin
          seg_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    corner_t got;
    corner_t want;
    if (!rst_n) begin
      vtx_bus.ready <= 1'b0;
      stall_left = 0;
      stall_seen = stall_toggle;
    end else begin
      if (vtx_bus.valid && vtx_bus.ready) begin
        got.x    = vtx_bus.vertex_x;
        got.y    = vtx_bus.vertex_y;
        got.u    = vtx_bus.corner_u;
        got.v    = vtx_bus.corner_v;
        got.num  = vtx_bus.vertex_number;
        got.last = vtx_bus.last_corner;
        if (corners_due.size() == 0) begin
          flag_mismatch($sformatf("vertex word %0d with nothing expected", got.num));
        end else begin
          want = corners_due.pop_front();
          corners_checked++;
          if (got.x !== want.x)
            flag_mismatch($sformatf("vertex %0d x: got %0d want %0d", want.num, got.x, want.x));
          if (got.y !== want.y)
            flag_mismatch($sformatf("vertex %0d y: got %0d want %0d", want.num, got.y, want.y));
          if (got.u !== want.u)
            flag_mismatch($sformatf("vertex %0d u: got %b want %b", want.num, got.u, want.u));
          if (got.v !== want.v)
            flag_mismatch($sformatf("vertex %0d v: got %b want %b", want.num, got.v, want.v));
          if (got.num !== want.num)
            flag_mismatch($sformatf("vertex number: got %0d want %0d", got.num, want.num));
          if (got.last !== want.last)
            flag_mismatch($sformatf("vertex %0d last: got %b want %b",
                                    want.num, got.last, want.last));
        end
      end
      if (stall_toggle != stall_seen) begin
        stall_seen = stall_toggle;
        stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        vtx_bus.ready <= 1'b0;
      end else begin
        vtx_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (seg_bus.valid && seg_bus.ready) || (vtx_bus.valid && vtx_bus.ready)
        || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_MAX) begin
      $display("timeout: no handshake for %0d cycles", WATCHDOG_MAX);
      $display("line_segment_quad_expander test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == HALF_WIDTH_ADDR) hw_shadow = data[HW_W-1:0];
  endtask

  task automatic check_half_width();
    logic [31:0] rd;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= HALF_WIDTH_ADDR;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[HW_W-1:0] !== hw_shadow)
      flag_mismatch($sformatf("half_width read %0d want %0d", rd[HW_W-1:0], hw_shadow));
  endtask

  task automatic push_seg(input longint sx, input longint sy, input longint ex,
                          input longint ey, input bit fs);
    segment_t s;
    s.sx = COORD_W'(sx);
    s.sy = COORD_W'(sy);
    s.ex = COORD_W'(ex);
    s.ey = COORD_W'(ey);
    s.frame_start = fs;
    seg_q = {seg_q, s};
    segs_sent++;
  endtask

  task automatic push_random(input int count);
    longint sx, sy, ex, ey, dx, dy;
    int kind;
    bit fs;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      fs = ($urandom_range(99) < 10);
      sx = longint'($signed(COORD_W'($urandom)));
      sy = longint'($signed(COORD_W'($urandom)));
      if (kind < 8) begin
        ex = sx;
        ey = sy;
      end else if (kind < 40) begin
        ex = longint'($signed(COORD_W'($urandom)));
        ey = longint'($signed(COORD_W'($urandom)));
      end else begin
        dx = $urandom_range(1 << $urandom_range(16));
        dy = $urandom_range(1 << $urandom_range(16));
        if ($urandom_range(1)) dx = -dx;
        if ($urandom_range(1)) dy = -dy;
        ex = clamp_coord(sx + dx);
        ey = clamp_coord(sy + dy);
      end
      push_seg(sx, sy, ex, ey, fs);
    end
  endtask

  task automatic set_pace(input int gap_pct, input int stall_pct);
    @(negedge clk);
    send_gap_pct   = gap_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic drain();
    while (segs_taken != segs_sent || corners_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_half_width(input logic [HW_W-1:0] hw);
    drain();
    apb_write(HALF_WIDTH_ADDR, 32'(hw));
    check_half_width();
    @(negedge clk);
  endtask

  initial begin
    logic [HW_W-1:0] mid_hw;
    rst_n = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    seg_bus.valid = 1'b0;
    seg_bus.start_x = '0;
    seg_bus.start_y = '0;
    seg_bus.end_x = '0;
    seg_bus.end_y = '0;
    seg_bus.frame_start = 1'b0;
    vtx_bus.ready = 1'b0;
    hw_shadow = HW_RESET;
    next_vertex = '0;
    stall_toggle = 1'b0;
    send_gap_pct = 9;
    recv_stall_pct = 58;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // reset half width, odd value exposes round-half-away ties
    check_half_width();
    @(negedge clk);
    push_seg(0, 0, 16384, 0, 1);
    push_seg(0, 0, 0, 16384, 0);
    push_seg(0, 0, 2, 1, 0);
    push_seg(0, 0, -2, -1, 0);
    push_seg(100, 100, 100, 100, 0);
    push_seg(7, 7, 7, 7, 1);
    push_seg(COORD_LO, COORD_LO, COORD_HI, COORD_HI, 0);
    push_seg(COORD_HI, COORD_LO, COORD_LO, COORD_HI, 0);
    push_seg(COORD_HI, COORD_HI, COORD_HI - 1, COORD_HI, 0);
    push_seg(COORD_LO, COORD_LO, COORD_LO, COORD_LO + 1, 0);
    push_seg(1, 1, 2, 2, 0);
    push_seg(COORD_LO, COORD_HI, COORD_LO, COORD_HI, 1);
    push_seg(0, 0, COORD_LO, 0, 0);
    push_seg(5000, -3000, -7000, 9000, 0);
    push_seg(COORD_HI, 0, COORD_LO, 0, 1);
    push_seg(0, COORD_HI, 0, COORD_LO, 0);

    set_half_width(16'd16384);
    apb_write(SPARE_ADDR, 32'h0000_1234);
    check_half_width();
    @(negedge clk);
    push_random(35);
    stall_toggle = ~stall_toggle;
    drain();
    push_random(15);

    set_half_width(16'hFFFF);
    set_pace(58, 9);
    push_random(30);

    set_half_width(16'd0);
    push_random(20);

    mid_hw = HW_W'($urandom_range(49152, 1));
    set_half_width(mid_hw);
    set_pace(0, 0);
    push_random(30);

    set_half_width(16'd49152);
    push_random(25);

    drain();
    if (corners_due.size() != 0)
      flag_mismatch($sformatf("%0d vertex words never arrived", corners_due.size()));
    $display("covered %0d segments (%0d zero length), %0d vertex words checked",
             segs_taken, degenerate_segs, corners_checked);
    $display("half widths 3, 16384, 65535, 0, %0d, 49152 with long output stall and drains",
             mid_hw);
    if (n_errors == 0) begin
      $display("line_segment_quad_expander test passed");
    end else begin
      $display("line_segment_quad_expander test failed");
    end
    $finish;
  end

endmodule
